### hdl/fsrt_pkg.sv
// Shared types, constants and codes for the floor search and remove table.
package fsrt_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int COUNT_WIDTH = 11;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_FINISH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic finish;
        logic out_clear;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_valid;
    } stat_t;

endpackage

### hdl/floor_search_remove_table_top.sv
// Top level of the floor search and remove table.
//  channel | beat contents                       | handshake
//  in      | operation, value                    | in_valid / in_ready
//  out     | status, found_value, entries_left   | out_valid / out_ready
// Each item scans every slot of the value RAM once, one slot a cycle through its
// single port, and its result then waits in the output until it is taken.
// Reset clears the valid marks and the count at once; no clearing pass is run.
// A new item is taken only after the previous result beat has left.
module floor_search_remove_table_top #(
    parameter int TABLE_DEPTH = fsrt_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = fsrt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [fsrt_pkg::FIELD_WIDTH-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [fsrt_pkg::FIELD_WIDTH-1:0]  found_value,
    output logic [fsrt_pkg::COUNT_WIDTH-1:0]  entries_left
);
    import fsrt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fsrt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_ready(out_ready), .cmd(cmd), .stat(stat)
    );

    fsrt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .operation(operation), .value(value),
        .cmd(cmd), .stat(stat), .status(status), .found_value(found_value),
        .entries_left(entries_left)
    );

    assign out_valid = stat.out_valid;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while result pending");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_left <= COUNT_WIDTH'(TABLE_DEPTH)) else $error("count overflow");
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_FOUND |-> found_value == '0)
        else $error("found_value nonzero without match");
`endif
endmodule

### hdl/fsrt_ram.sv
// Generic single-port RAM with a registered read.
module fsrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/fsrt_ctrl.sv
// Controller state machine that sequences the table scan.
module fsrt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_ready,
    output fsrt_pkg::cmd_t cmd,
    input  fsrt_pkg::stat_t stat
);
    import fsrt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (stat.scan_last) state_next = S_WAIT;
            S_WAIT:   state_next = S_FINISH;
            S_FINISH: state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                cmd.scan_start = in_valid;
            end
            S_SCAN:   cmd = '0;
            S_WAIT:   cmd = '0;
            S_FINISH: cmd.finish = 1'b1;
            S_OUT:    cmd.out_clear = out_ready;
            default:  cmd = '0;
        endcase
    end
endmodule

### hdl/fsrt_dp.sv
// Datapath: value store, valid marks, scan compare and result register.
module fsrt_dp #(
    parameter int TABLE_DEPTH = fsrt_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = fsrt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              operation,
    input  logic [fsrt_pkg::FIELD_WIDTH-1:0]  value,
    input  fsrt_pkg::cmd_t                    cmd,
    output fsrt_pkg::stat_t                   stat,
    output logic [1:0]                        status,
    output logic [fsrt_pkg::FIELD_WIDTH-1:0]  found_value,
    output logic [fsrt_pkg::COUNT_WIDTH-1:0]  entries_left
);
    import fsrt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   op_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [AW-1:0]          addr_reg;
    logic [AW-1:0]          cmp_addr_reg;
    logic                   cmp_valid_reg;
    logic                   cmp_live_reg;
    logic                   scan_run_reg;
    logic                   free_hit_reg;
    logic [AW-1:0]          free_idx_reg;
    logic                   best_hit_reg;
    logic [AW-1:0]          best_idx_reg;
    logic [VALUE_WIDTH-1:0] best_val_reg;
    logic [AW:0]            occ_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [VALUE_WIDTH-1:0] found_reg;

    logic                   we;
    logic [AW-1:0]          ram_addr;
    logic [VALUE_WIDTH-1:0] rdata;
    logic                   is_last;

    assign is_last = (addr_reg == AW'(TABLE_DEPTH - 1));
    assign we = cmd.finish && (op_reg == OP_INSERT) && free_hit_reg;
    assign ram_addr = we ? free_idx_reg : addr_reg;

    fsrt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(key_reg), .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            key_reg <= value[VALUE_WIDTH-1:0];
        end
        cmp_addr_reg <= addr_reg;
        cmp_valid_reg <= valid_reg[addr_reg];
        if (cmd.scan_start)
        begin
            addr_reg <= '0;
        end
        else if (scan_run_reg && !is_last)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        if (cmd.scan_start)
        begin
            free_hit_reg <= 1'b0;
            best_hit_reg <= 1'b0;
        end
        else if (cmp_live_reg)
        begin
            if (!cmp_valid_reg && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= cmp_addr_reg;
            end
            if (cmp_valid_reg && rdata <= key_reg &&
                (!best_hit_reg || rdata > best_val_reg))
            begin
                best_hit_reg <= 1'b1;
                best_idx_reg <= cmp_addr_reg;
                best_val_reg <= rdata;
            end
        end
        if (cmd.finish)
        begin
            found_reg <= '0;
            if (op_reg == OP_INSERT)
            begin
                status_reg <= free_hit_reg ? ST_INSERTED : ST_FULL;
            end
            else if (best_hit_reg)
            begin
                status_reg <= ST_FOUND;
                found_reg <= best_val_reg;
            end
            else
            begin
                status_reg <= ST_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg <= '0;
            out_valid_reg <= 1'b0;
            scan_run_reg <= 1'b0;
            cmp_live_reg <= 1'b0;
        end
        else
        begin
            cmp_live_reg <= scan_run_reg;
            if (cmd.scan_start)
            begin
                scan_run_reg <= 1'b1;
            end
            else if (is_last)
            begin
                scan_run_reg <= 1'b0;
            end
            if (we)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg <= occ_reg + 1'b1;
            end
            else if (cmd.finish && op_reg == OP_QUERY && best_hit_reg)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                occ_reg <= occ_reg - 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_clear)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_last = is_last;
    assign stat.out_valid = out_valid_reg;
    assign status = status_reg;
    assign found_value = FIELD_WIDTH'(found_reg);
    assign entries_left = COUNT_WIDTH'(occ_reg);
endmodule
